>>> rtl/pcew_pkg.sv
// ----------------------------------------------------------------------------
// pcew_pkg
// Shared types and constants of the PCI class enumeration walker.
// ----------------------------------------------------------------------------
package pcew_pkg;

  localparam int MAX_NEST   = 4;
  localparam int MAX_FOUND  = 8;
  localparam int LEVELS     = MAX_NEST + 1;
  localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int STACK_D    = (MAX_NEST > 0) ? MAX_NEST : 1;
  localparam int STK_W      = (STACK_D > 1) ? $clog2(STACK_D) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int CNT_W      = 4;

  localparam logic [5:0] OFF_ID    = 6'd0;
  localparam logic [5:0] OFF_CLASS = 6'd2;
  localparam logic [5:0] OFF_HDR   = 6'd3;
  localparam logic [5:0] OFF_BUS   = 6'd6;

  localparam logic [7:0]       CLASS_BRIDGE = 8'h06;
  localparam logic [7:0]       SUB_P2P      = 8'h04;
  localparam logic [7:0]       PI_ANY       = 8'hFF;
  localparam logic [4:0]       LAST_DEV     = 5'd31;
  localparam logic [2:0]       LAST_FN      = 3'd7;
  localparam logic [CNT_W-1:0] COUNT_SAT    = '1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_FOUND = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_CLASS = 2'd1,
    PH_BUS   = 2'd2,
    PH_HDR   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] bus;
    logic [4:0] dev;
    logic [2:0] fn;
  } frame_t;

  // one entry per input that causes results: optional found, then main result
  typedef struct packed {
    logic             has_found;
    kind_t            kind;
    frame_t           addr;
    logic [5:0]       off;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_bus_t;

endpackage

>>> rtl/pcew_if.sv
// ----------------------------------------------------------------------------
// pcew_if
// Valid/ready channels of the walker: command/read data in, results out.
// ----------------------------------------------------------------------------
interface pcew_cmd_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  class_code;
  logic [7:0]  subclass_code;
  logic [7:0]  prog_interface;
  logic [3:0]  result_limit;
  logic [31:0] read_data;

  modport source (
    output valid, mode, class_code, subclass_code, prog_interface, result_limit,
           read_data,
    input  ready
  );
  modport sink (
    input  valid, mode, class_code, subclass_code, prog_interface, result_limit,
           read_data,
    output ready
  );
endinterface

interface pcew_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] req_bus;
  logic [4:0] req_device;
  logic [2:0] req_function;
  logic [5:0] req_dword_offset;
  logic [3:0] found_count;
  logic       last_of_run;

  modport source (
    output valid, result_kind, req_bus, req_device, req_function, req_dword_offset,
           found_count, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, req_bus, req_device, req_function, req_dword_offset,
           found_count, last_of_run,
    output ready
  );
endinterface

>>> rtl/pcew_front.sv
// ----------------------------------------------------------------------------
// pcew_front
// Walker state: takes start and read data transactions, steps the
// depth-first walk and queues the results each one causes.
// ----------------------------------------------------------------------------
module pcew_front
  import pcew_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pcew_cmd_if.sink      cmd,
  input  logic          full,
  output job_bus_t      push
);

  frame_t           cur;
  frame_t           cur_next;
  frame_t           stack [STACK_D];
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  logic [LVL_W-1:0] level_dec;
  phase_t           phase;
  phase_t           phase_next;
  logic             busy;
  logic             busy_next;
  logic [CNT_W-1:0] match_total;
  logic [CNT_W-1:0] match_total_next;
  logic [7:0]       sought_class;
  logic [7:0]       sought_subclass;
  logic [7:0]       sought_interface;
  logic [CNT_W-1:0] limit_held;
  logic [CNT_W-1:0] limit_next;
  logic [CNT_W-1:0] lim_clamped;
  logic             latch_start;
  logic             stk_we;
  logic             go_fn;
  logic             go_dev;
  logic             adv_ok;
  logic             accept;
  logic             class_hit;
  logic [7:0]       rd_class;
  logic [7:0]       rd_sub;
  logic [7:0]       rd_pi;

  assign cmd.ready   = !full;
  assign accept      = cmd.valid && cmd.ready;
  assign level_dec   = level - LVL_W'(1);
  assign rd_class    = cmd.read_data[23:16];
  assign rd_sub      = cmd.read_data[15:8];
  assign rd_pi       = cmd.read_data[7:0];
  assign lim_clamped = (cmd.result_limit > CNT_W'(MAX_FOUND)) ? CNT_W'(MAX_FOUND)
                                                              : cmd.result_limit;
  assign class_hit   = (rd_class == sought_class) && (rd_sub == sought_subclass) &&
                       ((sought_interface == PI_ANY) || (rd_pi == sought_interface));

  always_comb begin
    cur_next         = cur;
    level_next       = level;
    phase_next       = phase;
    busy_next        = busy;
    match_total_next = match_total;
    limit_next       = limit_held;
    latch_start      = 1'b0;
    stk_we           = 1'b0;
    go_fn            = 1'b0;
    go_dev           = 1'b0;
    push             = '0;
    push.job.kind    = KIND_READ;

    if (accept && !cmd.mode) begin
      latch_start      = 1'b1;
      limit_next       = lim_clamped;
      match_total_next = '0;
      level_next       = '0;
      cur_next         = '0;
      push.valid       = 1'b1;
      if (lim_clamped == '0) begin
        busy_next     = 1'b0;
        phase_next    = PH_ID;
        push.job.kind = KIND_DONE;
      end else begin
        busy_next     = 1'b1;
        phase_next    = PH_ID;
        push.job.off  = OFF_ID;
      end
    end else if (accept && busy) begin
      push.valid = 1'b1;
      case (phase)
        PH_ID: begin
          if (cmd.read_data == '1) begin
            if (cur.fn == '0) go_dev = 1'b1;
            else go_fn = 1'b1;
          end else begin
            phase_next   = PH_CLASS;
            push.job.off = OFF_CLASS;
          end
        end
        PH_CLASS: begin
          if (class_hit) begin
            push.job.has_found = 1'b1;
            if (match_total < COUNT_SAT) match_total_next = match_total + CNT_W'(1);
          end
          if ((rd_class == CLASS_BRIDGE) && (rd_sub == SUB_P2P)) begin
            phase_next   = PH_BUS;
            push.job.off = OFF_BUS;
          end else begin
            phase_next   = PH_HDR;
            push.job.off = OFF_HDR;
          end
        end
        PH_BUS: begin
          if ((cmd.read_data[15:8] != cur.bus) && (level < LVL_W'(MAX_NEST)) &&
              (match_total < limit_held)) begin
            stk_we       = 1'b1;
            level_next   = level + LVL_W'(1);
            cur_next     = '{bus: cmd.read_data[15:8], dev: '0, fn: '0};
            phase_next   = PH_ID;
            push.job.off = OFF_ID;
          end else begin
            phase_next   = PH_HDR;
            push.job.off = OFF_HDR;
          end
        end
        PH_HDR: begin
          // header type bit 7 marks a multifunction device
          if (!cmd.read_data[23]) go_dev = 1'b1;
          else go_fn = 1'b1;
        end
        default: begin
          phase_next = PH_ID;
        end
      endcase
    end

    // advance to the next function, device or parent bus
    adv_ok = match_total_next < limit_held;
    if (go_fn && (cur.fn < LAST_FN) && adv_ok) begin
      cur_next.fn  = cur.fn + 3'd1;
      phase_next   = PH_ID;
      push.job.off = OFF_ID;
    end else if ((go_fn || go_dev) && (cur.dev < LAST_DEV) && adv_ok) begin
      cur_next.dev = cur.dev + 5'd1;
      cur_next.fn  = '0;
      phase_next   = PH_ID;
      push.job.off = OFF_ID;
    end else if (go_fn || go_dev) begin
      if (level == '0) begin
        busy_next     = 1'b0;
        phase_next    = PH_ID;
        level_next    = '0;
        push.job.kind = KIND_DONE;
      end else begin
        level_next   = level_dec;
        cur_next     = stack[level_dec[STK_W-1:0]];
        phase_next   = PH_HDR;
        push.job.off = OFF_HDR;
      end
    end

    push.job.count = match_total_next;
    if (push.job.kind == KIND_DONE) begin
      push.job.addr = '0;
      push.job.off  = '0;
    end else begin
      push.job.addr = cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur         <= '0;
      level       <= '0;
      phase       <= PH_ID;
      busy        <= 1'b0;
      match_total <= '0;
      limit_held  <= '0;
    end else begin
      cur         <= cur_next;
      level       <= level_next;
      phase       <= phase_next;
      busy        <= busy_next;
      match_total <= match_total_next;
      limit_held  <= limit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sought_class     <= '0;
      sought_subclass  <= '0;
      sought_interface <= '0;
    end else if (latch_start) begin
      sought_class     <= cmd.class_code;
      sought_subclass  <= cmd.subclass_code;
      sought_interface <= cmd.prog_interface;
    end
  end

  // parent frames; the current frame lives in cur
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[level[STK_W-1:0]] <= cur;
    end
  end

endmodule

>>> rtl/pcew_fifo.sv
// ----------------------------------------------------------------------------
// pcew_fifo
// Short queue of result jobs between the walker and the output stage.
// ----------------------------------------------------------------------------
module pcew_fifo
  import pcew_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  job_bus_t push,
  output logic     full,
  output job_bus_t head,
  input  logic     pop
);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == FIFO_CW'(FIFO_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + FIFO_CW'(1);
        2'b01:   count <= count - FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/pcew_back.sv
// ----------------------------------------------------------------------------
// pcew_back
// Output stage: holds one job and sends its found result, if any, then its
// read request or done result.
// ----------------------------------------------------------------------------
module pcew_back
  import pcew_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_bus_t  head,
  output logic      pop,
  pcew_res_if.source res
);

  job_t hold;
  logic hold_valid;
  logic second;
  logic last_beat;
  logic out_fire;

  assign last_beat = !hold.has_found || second;
  assign out_fire  = hold_valid && res.ready;
  assign pop       = head.valid && (!hold_valid || (out_fire && last_beat));

  always_comb begin
    res.valid        = hold_valid;
    res.req_bus      = hold.addr.bus;
    res.req_device   = hold.addr.dev;
    res.req_function = hold.addr.fn;
    res.found_count  = hold.count;
    if (hold.has_found && !second) begin
      res.result_kind      = KIND_FOUND;
      res.req_dword_offset = '0;
      res.last_of_run      = 1'b0;
    end else begin
      res.result_kind      = hold.kind;
      res.req_dword_offset = hold.off;
      res.last_of_run      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      second     <= 1'b0;
    end else if (pop) begin
      hold_valid <= 1'b1;
      second     <= 1'b0;
    end else if (out_fire) begin
      if (last_beat) begin
        hold_valid <= 1'b0;
        second     <= 1'b0;
      end else begin
        second     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= head.job;
    end
  end

endmodule

>>> rtl/pci_class_enumeration_walker_core.sv
// ----------------------------------------------------------------------------
// pci_class_enumeration_walker_core
// Depth-first PCI class search: issues config reads, reports matching
// functions and a final count.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  cmd     | in  | valid/ready  | mode, class/subclass/interface, limit, read_data
//  res     | out | valid/ready  | kind, bus/device/function, dword offset, count, last
//
// the front takes one transaction per cycle while the 4-entry job queue has room
// each accepted transaction is decided in the cycle it arrives
// the output stage sends one result per cycle; a match and its read are two results
// res stalls fill the queue and then drop cmd.ready; no clearing pass after reset
module pci_class_enumeration_walker_core
  import pcew_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pcew_cmd_if.sink   cmd,
  pcew_res_if.source res
);

  job_bus_t push;
  job_bus_t head;
  logic     full;
  logic     pop;

  pcew_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .full (full),
    .push (push)
  );

  pcew_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  pcew_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

  // every start transaction queues exactly one job
  a_start_pushes: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && !cmd.mode) |-> push.valid)
    else $error("start transaction did not queue a job");

  // no job appears without an accepted transaction
  a_push_has_source: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (cmd.valid && cmd.ready))
    else $error("job queued without a transaction");

  // only a found result can be followed by another from the same input
  a_not_last_is_found: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last_of_run) |-> (res.result_kind == KIND_FOUND))
    else $error("non-final result that is not a found");

  // a found result is always followed by its read request
  a_found_then_read: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && !res.last_of_run) |=>
      (res.valid && res.last_of_run && (res.result_kind == KIND_READ)))
    else $error("found result not followed by read request");

endmodule
